// ===== src/hbfe_pkg.sv =====
`timescale 1ns / 1ps

package hbfe_pkg;

	// Widths of the stream and of the 7-bit wrapping positions.
	localparam int BYTE_W = 8;
	localparam int POS_W = 7;
	localparam int LEN_W = 6;

	// Storage sizes.
	localparam int RING_DEPTH = 64;
	localparam int RING_AW = 6;
	localparam int QUEUE_DEPTH = 64;
	localparam int QUEUE_AW = 6;

	// Default frame window in bytes.
	localparam int MAX_FRAME_DEF = 64;

	// Delimiters and check digit range.
	localparam logic [BYTE_W-1:0] START_MARK = 8'h23;
	localparam logic [BYTE_W-1:0] END_MARK = 8'h21;
	localparam logic [BYTE_W-1:0] DIGIT_LOW = 8'h30;
	localparam logic [BYTE_W-1:0] DIGIT_HIGH = 8'h39;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LEN_W-1:0] len_t;

	// Frame sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_START,
		ST_CHECK,
		ST_READ,
		ST_EMIT
	} hbfe_state_t;

	// Status from the start tracker to the frame sequencer.
	typedef struct packed {
		logic frame_close;
		logic reload;
		pos_t start;
	} hbfe_trk_t;

endpackage

// ===== src/hbfe_ram.sv =====
`timescale 1ns / 1ps

module hbfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/hbfe_start_tracker.sv =====
`timescale 1ns / 1ps

module hbfe_start_tracker #(
	parameter int MAX_FRAME = hbfe_pkg::MAX_FRAME_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [hbfe_pkg::BYTE_W-1:0]       stream_byte,
	input  hbfe_pkg::pos_t                    position,
	output hbfe_pkg::hbfe_trk_t               trk
);

	localparam hbfe_pkg::pos_t MAX_AGE = hbfe_pkg::pos_t'(MAX_FRAME);
	localparam hbfe_pkg::pos_t QUEUE_FULL = hbfe_pkg::pos_t'(hbfe_pkg::QUEUE_DEPTH);

	hbfe_pkg::pos_t head_q;
	hbfe_pkg::pos_t tail_q;
	hbfe_pkg::pos_t cand_q;
	logic           load_q;
	logic           use_rd_q;

	hbfe_pkg::pos_t count;
	hbfe_pkg::pos_t age;
	hbfe_pkg::pos_t head1;
	hbfe_pkg::pos_t count1;
	hbfe_pkg::pos_t head_fin;
	logic           stale;
	logic           is_start;
	logic           is_end;
	logic           full;
	logic           reload;
	logic           rd_en;
	logic           wr_en;
	logic [hbfe_pkg::QUEUE_AW-1:0] rd_addr;
	hbfe_pkg::pos_t rd_data;

	// Age check of the cached head entry, queue full check and read selection.
	always_comb begin
		count = tail_q - head_q;
		age = position - cand_q;
		stale = (count != '0) && (age > MAX_AGE);
		head1 = head_q + hbfe_pkg::pos_t'(stale);
		count1 = count - hbfe_pkg::pos_t'(stale);
		is_start = (stream_byte == hbfe_pkg::START_MARK);
		is_end = (stream_byte == hbfe_pkg::END_MARK) && (count1 != '0);
		full = (count1 == QUEUE_FULL);
		head_fin = head1 + hbfe_pkg::pos_t'(is_start && full);
		reload = !is_end && (stale || (is_start && full)) && (count1 != '0);
		rd_en = accept && ((is_end && stale) || reload);
		rd_addr = is_end ? head1[hbfe_pkg::QUEUE_AW-1:0] : head_fin[hbfe_pkg::QUEUE_AW-1:0];
		wr_en = accept && is_start;
		trk.frame_close = is_end;
		trk.reload = reload;
		trk.start = use_rd_q ? rd_data : cand_q;
	end

	hbfe_ram #(
		.WIDTH(hbfe_pkg::POS_W),
		.DEPTH(hbfe_pkg::QUEUE_DEPTH)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q[hbfe_pkg::QUEUE_AW-1:0]),
		.wr_data(position),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Head, tail and the cached head entry of the start queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cand_q <= '0;
			load_q <= 1'b0;
			use_rd_q <= 1'b0;
		end else if (accept) begin
			load_q <= reload;
			if (is_end) begin
				head_q <= tail_q;
				use_rd_q <= stale;
			end else begin
				head_q <= head_fin;
				use_rd_q <= 1'b0;
				if (is_start) begin
					tail_q <= tail_q + 1'b1;
				end
				if (is_start && (count1 == '0)) begin
					cand_q <= position;
				end
			end
		end else if (load_q) begin
			cand_q <= rd_data;
			load_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q - head_q) <= QUEUE_FULL)
		else $error("start queue holds more entries than it has");

	a_no_accept_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> !accept)
		else $error("transaction accepted while the head entry is being refetched");
`endif

endmodule

// ===== src/hash_bang_frame_extractor.sv =====
`timescale 1ns / 1ps

// A byte other than a closing '!' is taken at once, or the input stalls in LOAD while the
// start queue head is refetched after a start mark expires or is pushed out of a full queue.
// A '!' that closes a frame stalls the input through START and CHECK, then READ and EMIT per
// payload byte, EMIT waiting while the output is stalled; a frame with nothing to emit ends in
// START or CHECK. The single ring read port takes one payload byte at a time: READ, then EMIT.
// Reset clears the positions, the queue pointers and the output valid; memories are not cleared.
module hash_bang_frame_extractor #(
	parameter int MAX_FRAME = hbfe_pkg::MAX_FRAME_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        stream_valid,
	output logic                        stream_stall,
	input  logic [hbfe_pkg::BYTE_W-1:0] stream_byte,
	output logic                        payload_valid,
	input  logic                        payload_stall,
	output logic [hbfe_pkg::BYTE_W-1:0] payload_byte,
	output logic                        last_byte,
	output logic [hbfe_pkg::LEN_W-1:0]  payload_length
);

	localparam hbfe_pkg::pos_t LEN_MAX = hbfe_pkg::pos_t'({hbfe_pkg::LEN_W{1'b1}});

	hbfe_pkg::hbfe_state_t state_q;
	hbfe_pkg::hbfe_state_t state_d;
	hbfe_pkg::hbfe_trk_t   trk;

	hbfe_pkg::pos_t byte_position_q;
	hbfe_pkg::pos_t first_q;
	hbfe_pkg::len_t len_q;
	hbfe_pkg::len_t k_q;
	logic           payload_valid_q;
	logic [hbfe_pkg::BYTE_W-1:0] payload_byte_q;
	logic           last_byte_q;
	hbfe_pkg::len_t payload_length_q;

	logic           accept;
	logic           out_free;
	logic           out_load;
	logic           frame_last;
	logic           digit;
	logic           ring_rd_en;
	logic [hbfe_pkg::RING_AW-1:0] ring_rd_addr;
	logic [hbfe_pkg::BYTE_W-1:0]  ring_rd_data;
	hbfe_pkg::pos_t start_age;
	hbfe_pkg::pos_t start_len;
	hbfe_pkg::pos_t start_first;
	hbfe_pkg::pos_t frame_pos;

	hbfe_start_tracker #(
		.MAX_FRAME(MAX_FRAME)
	) u_start_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.stream_byte(stream_byte),
		.position   (byte_position_q),
		.trk        (trk)
	);

	hbfe_ram #(
		.WIDTH(hbfe_pkg::BYTE_W),
		.DEPTH(hbfe_pkg::RING_DEPTH)
	) u_ring_ram (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(byte_position_q[hbfe_pkg::RING_AW-1:0]),
		.wr_data(stream_byte),
		.rd_en  (ring_rd_en),
		.rd_addr(ring_rd_addr),
		.rd_data(ring_rd_data)
	);

	// Frame geometry, check digit test and the next state of the sequencer.
	always_comb begin
		stream_stall = (state_q != hbfe_pkg::ST_IDLE);
		accept = stream_valid && !stream_stall;
		out_free = !payload_valid_q || !payload_stall;
		start_age = byte_position_q - 1'b1 - trk.start;
		start_len = start_age - 1'b1;
		start_first = trk.start + 1'b1;
		frame_pos = first_q + hbfe_pkg::pos_t'(k_q);
		frame_last = (k_q == len_q - 1'b1);
		digit = ring_rd_data inside {[hbfe_pkg::DIGIT_LOW:hbfe_pkg::DIGIT_HIGH]};
		ring_rd_en = 1'b0;
		ring_rd_addr = frame_pos[hbfe_pkg::RING_AW-1:0];
		out_load = 1'b0;
		state_d = state_q;
		case (state_q)
			hbfe_pkg::ST_IDLE: begin
				if (accept) begin
					if (trk.frame_close) begin
						state_d = hbfe_pkg::ST_START;
					end else if (trk.reload) begin
						state_d = hbfe_pkg::ST_LOAD;
					end
				end
			end
			hbfe_pkg::ST_LOAD: begin
				state_d = hbfe_pkg::ST_IDLE;
			end
			hbfe_pkg::ST_START: begin
				if (start_len != '0) begin
					ring_rd_en = 1'b1;
					ring_rd_addr = start_first[hbfe_pkg::RING_AW-1:0];
					state_d = hbfe_pkg::ST_CHECK;
				end else begin
					state_d = hbfe_pkg::ST_IDLE;
				end
			end
			hbfe_pkg::ST_CHECK: begin
				if (digit && (len_q == hbfe_pkg::len_t'(1))) begin
					state_d = hbfe_pkg::ST_IDLE;
				end else begin
					state_d = hbfe_pkg::ST_READ;
				end
			end
			hbfe_pkg::ST_READ: begin
				ring_rd_en = 1'b1;
				state_d = hbfe_pkg::ST_EMIT;
			end
			hbfe_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = frame_last ? hbfe_pkg::ST_IDLE : hbfe_pkg::ST_READ;
				end
			end
			default: begin
				state_d = hbfe_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer state, stream position, frame bounds and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbfe_pkg::ST_IDLE;
			byte_position_q <= '0;
			first_q <= '0;
			len_q <= '0;
			k_q <= '0;
			payload_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				byte_position_q <= byte_position_q + 1'b1;
			end
			if (state_q == hbfe_pkg::ST_START) begin
				first_q <= start_first;
				len_q <= (start_len > LEN_MAX) ? hbfe_pkg::len_t'(LEN_MAX)
					: start_len[hbfe_pkg::LEN_W-1:0];
			end
			if (state_q == hbfe_pkg::ST_CHECK) begin
				k_q <= '0;
				if (digit) begin
					first_q <= first_q + 1'b1;
					len_q <= len_q - 1'b1;
				end
			end
			if (out_load) begin
				k_q <= k_q + 1'b1;
			end
			if (out_load) begin
				payload_valid_q <= 1'b1;
			end else if (!payload_stall) begin
				payload_valid_q <= 1'b0;
			end
		end
	end

	// Output transaction payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			payload_byte_q <= ring_rd_data;
			last_byte_q <= frame_last;
			payload_length_q <= len_q;
		end
	end

	assign payload_valid = payload_valid_q;
	assign payload_byte = payload_byte_q;
	assign last_byte = last_byte_q;
	assign payload_length = payload_length_q;

`ifndef ASSERT_OFF
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		payload_valid |-> (payload_length != '0))
		else $error("payload transaction with zero length");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbfe_pkg::ST_EMIT) |-> (k_q < len_q))
		else $error("drain index runs past the frame length");

	a_start_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbfe_pkg::ST_START) |-> $past(accept))
		else $error("frame start without a closing transaction");
`endif

endmodule

// ===== verif/tb_hash_bang_frame_extractor.sv =====
`timescale 1ns / 1ps

module tb_hash_bang_frame_extractor;

	localparam int FRAME_WINDOW = hbfe_pkg::MAX_FRAME_DEF;
	localparam int RANDOM_BYTES = 420;
	localparam int DRAIN_CYCLES = 150;

	// One byte offered to the block, optionally held back until all output has drained.
	typedef struct {
		logic [hbfe_pkg::BYTE_W-1:0] data;
		bit                          hold;
	} stream_item_t;

	// One expected output transaction.
	typedef struct {
		logic [hbfe_pkg::BYTE_W-1:0] data;
		logic                        last;
		hbfe_pkg::len_t              len;
	} payload_beat_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        stream_valid = 1'b0;
	logic                        stream_stall;
	logic [hbfe_pkg::BYTE_W-1:0] stream_byte = '0;
	logic                        payload_valid;
	logic                        payload_stall = 1'b0;
	logic [hbfe_pkg::BYTE_W-1:0] payload_byte;
	logic                        last_byte;
	logic [hbfe_pkg::LEN_W-1:0]  payload_length;

	stream_item_t  pending_bytes[$];
	payload_beat_t expected_beats[$];
	int            fail_count = 0;

	// Shadow copy of the deframer state.
	logic [hbfe_pkg::BYTE_W-1:0] shadow_ring [hbfe_pkg::RING_DEPTH];
	hbfe_pkg::pos_t              shadow_starts [hbfe_pkg::QUEUE_DEPTH];
	hbfe_pkg::pos_t              start_head = '0;
	hbfe_pkg::pos_t              start_tail = '0;
	hbfe_pkg::pos_t              next_position = '0;

	// Driver and monitor pacing.
	int           tx_gap = 0;
	bit           tx_steady = 1'b0;
	stream_item_t next_item;
	int           rx_hold = 0;
	bit           rx_steady = 1'b0;
	payload_beat_t want;

	hash_bang_frame_extractor #(
		.MAX_FRAME(FRAME_WINDOW)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream_valid  (stream_valid),
		.stream_stall  (stream_stall),
		.stream_byte   (stream_byte),
		.payload_valid (payload_valid),
		.payload_stall (payload_stall),
		.payload_byte  (payload_byte),
		.last_byte     (last_byte),
		.payload_length(payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < hbfe_pkg::RING_DEPTH; i++)
			shadow_ring[i] = '0;
		for (int i = 0; i < hbfe_pkg::QUEUE_DEPTH; i++)
			shadow_starts[i] = '0;
	end

	// Number of start marks currently queued, modulo the position range.
	function automatic hbfe_pkg::pos_t queued_starts();
		hbfe_pkg::pos_t count;
		count = start_tail - start_head;
		return count;
	endfunction

	// Distance in bytes from a queued start to the byte being taken.
	function automatic hbfe_pkg::pos_t start_age(input hbfe_pkg::pos_t at);
		hbfe_pkg::pos_t age;
		age = next_position - at;
		return age;
	endfunction

	// Advance the shadow state by one accepted byte and queue the payload it releases.
	task automatic track_stream_byte(input logic [hbfe_pkg::BYTE_W-1:0] b);
		hbfe_pkg::pos_t first;
		hbfe_pkg::pos_t at;
		int unsigned    span;
		payload_beat_t  beat;
		shadow_ring[next_position[hbfe_pkg::RING_AW-1:0]] = b;

		// Start marks that fell out of the window are retired first.
		while (queued_starts() != 0 &&
			start_age(shadow_starts[start_head[hbfe_pkg::QUEUE_AW-1:0]]) > FRAME_WINDOW)
			start_head = start_head + 1'b1;

		// A closing mark with a live candidate releases the bytes in between.
		if (b == hbfe_pkg::END_MARK && queued_starts() != 0) begin
			first = shadow_starts[start_head[hbfe_pkg::QUEUE_AW-1:0]] + 1'b1;
			span = start_age(shadow_starts[start_head[hbfe_pkg::QUEUE_AW-1:0]]) - 1;
			if (span > 0 && shadow_ring[first[hbfe_pkg::RING_AW-1:0]] >= hbfe_pkg::DIGIT_LOW &&
				shadow_ring[first[hbfe_pkg::RING_AW-1:0]] <= hbfe_pkg::DIGIT_HIGH) begin
				first = first + 1'b1;
				span--;
			end
			if (span > 63)
				span = 63;
			for (int k = 0; k < span; k++) begin
				at = first + hbfe_pkg::pos_t'(k);
				beat.data = shadow_ring[at[hbfe_pkg::RING_AW-1:0]];
				beat.last = (k == span - 1);
				beat.len = hbfe_pkg::len_t'(span);
				expected_beats.insert(expected_beats.size(), beat);
			end
			start_head = start_tail;
		end

		// A new start mark pushes out the oldest one when the queue is full.
		if (b == hbfe_pkg::START_MARK) begin
			if (queued_starts() >= hbfe_pkg::QUEUE_DEPTH)
				start_head = start_head + 1'b1;
			shadow_starts[start_tail[hbfe_pkg::QUEUE_AW-1:0]] = next_position;
			start_tail = start_tail + 1'b1;
		end
		next_position = next_position + 1'b1;
	endtask

	// Driver: presents pending bytes with random gaps and tracks each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_valid <= 1'b0;
			stream_byte <= '0;
			tx_gap = 0;
		end else begin
			if (stream_valid && !stream_stall)
				track_stream_byte(stream_byte);
			if (!stream_valid || !stream_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					stream_valid <= 1'b0;
				end else if (pending_bytes.size() != 0 &&
					!(pending_bytes[0].hold && expected_beats.size() != 0)) begin
					next_item = pending_bytes.pop_front();
					stream_valid <= 1'b1;
					stream_byte <= next_item.data;
					if ($urandom_range(0, 31) == 0)
						tx_steady = !tx_steady;
					tx_gap = tx_steady ? 0 : $urandom_range(0, 7);
				end else begin
					stream_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted output transaction and paces the stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (payload_valid && !payload_stall) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected payload transaction: byte %0h last %0b length %0d",
						payload_byte, last_byte, payload_length);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (payload_byte !== want.data) begin
						$error("payload_byte mismatch: expected %0h, actual %0h",
							want.data, payload_byte);
						fail_count++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte mismatch: expected %0b, actual %0b",
							want.last, last_byte);
						fail_count++;
					end
					if (payload_length !== want.len) begin
						$error("payload_length mismatch: expected %0d, actual %0d",
							want.len, payload_length);
						fail_count++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				rx_hold = rx_steady ? 0 : $urandom_range(0, 7);
			end else if (!payload_valid && rx_hold == 0 && !rx_steady &&
				$urandom_range(0, 7) == 0) begin
				rx_hold = $urandom_range(1, 7);
			end
			if (rx_hold > 0) begin
				payload_stall <= 1'b1;
				rx_hold--;
			end else begin
				payload_stall <= 1'b0;
			end
		end
	end

	task automatic add_byte(input logic [hbfe_pkg::BYTE_W-1:0] b, input bit hold);
		stream_item_t item;
		item.data = b;
		item.hold = hold;
		pending_bytes.insert(pending_bytes.size(), item);
	endtask

	task automatic add_text(input string s, input bit hold);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], hold && i == 0);
	endtask

	// Random byte that never closes a frame, and optionally never opens one.
	function automatic logic [hbfe_pkg::BYTE_W-1:0] rand_data(input bit no_start);
		logic [hbfe_pkg::BYTE_W-1:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == hbfe_pkg::END_MARK || (no_start && b == hbfe_pkg::START_MARK));
		return b;
	endfunction

	// Mostly short bodies, with an occasional long one up to the window.
	function automatic int draw_body_len(input int limit);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			n = $urandom_range(0, 8);
		else if (pick < 95)
			n = $urandom_range(9, 30);
		else
			n = $urandom_range(31, 63);
		return (n > limit) ? limit : n;
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		int kind;
		int n;
		int k;
		int m;
		int seq;
		int counted;
		int mark;
		bit hold;
		bit digit;

		// Noise and a stray closing mark before any start.
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(hbfe_pkg::END_MARK, 1'b0);
		// Empty payload, and a payload made only of a check digit.
		add_text("#!", 1'b0);
		add_text("#9!", 1'b0);
		// Check digit stripped, start mark inside the payload kept as data.
		add_text("#0x#y!", 1'b0);
		// Characters just outside the digit range are not stripped.
		add_text("#/:!", 1'b0);
		// Single byte payload after a full drain.
		add_text("#z!", 1'b1);
		add_byte(hbfe_pkg::START_MARK, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(hbfe_pkg::END_MARK, 1'b0);

		seq = 0;
		counted = pending_bytes.size();
		while (counted < RANDOM_BYTES) begin
			mark = pending_bytes.size();
			hold = (seq % 8 == 0);
			kind = $urandom_range(0, 99);
			if (seq == 4) begin
				// Overfill the start queue, then close on the survivors.
				for (int i = 0; i < hbfe_pkg::QUEUE_DEPTH + 2; i++)
					add_byte(hbfe_pkg::START_MARK, hold && i == 0);
				add_byte(rand_data(1'b1), 1'b0);
				add_byte(hbfe_pkg::END_MARK, 1'b0);
			end else if (kind < 70) begin
				// Well-formed frame with random content.
				digit = 1'($urandom_range(0, 1));
				add_byte(hbfe_pkg::START_MARK, hold);
				if (digit)
					add_byte(8'(hbfe_pkg::DIGIT_LOW + $urandom_range(0, 9)), 1'b0);
				n = draw_body_len(63 - digit);
				for (int i = 0; i < n; i++)
					add_byte(($urandom_range(0, 11) == 0) ? hbfe_pkg::START_MARK
						: rand_data(1'b0), 1'b0);
				add_byte(hbfe_pkg::END_MARK, 1'b0);
			end else if (kind < 82) begin
				// Loose noise, closing marks included.
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					add_byte(($urandom_range(0, 3) == 0) ? hbfe_pkg::END_MARK
						: 8'($urandom_range(0, 255)), hold && i == 0);
			end else if (kind < 92) begin
				// The first start expires before the close; the second one wins.
				k = $urandom_range(40, 62);
				m = $urandom_range(23, 40);
				add_byte(hbfe_pkg::START_MARK, hold);
				for (int i = 0; i < k; i++)
					add_byte(rand_data(1'b1), 1'b0);
				add_byte(hbfe_pkg::START_MARK, 1'b0);
				for (int i = 0; i < m; i++)
					add_byte(rand_data(1'b1), 1'b0);
				add_byte(hbfe_pkg::END_MARK, 1'b0);
			end else begin
				// Unterminated frame left for a later close to pick up.
				add_byte(hbfe_pkg::START_MARK, hold);
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					add_byte(rand_data(1'b0), 1'b0);
			end
			counted += pending_bytes.size() - mark;
			seq++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || stream_valid)
			@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
